FILE: src/rgbfb_pkg.sv
// Shared constants, operation codes and helpers for the framebuffer span engine.
// No dependencies; used by the item interfaces and the top level.
package rgbfb_pkg;

    localparam int unsigned MAX_WIDTH   = 256;
    localparam int unsigned MAX_HEIGHT  = 256;
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

    localparam int unsigned DIM_W   = 9;    // size register width
    localparam int unsigned COORD_W = 8;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIX_W   = 3 * CHAN_W;
    localparam int unsigned LUMA_W  = 16;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_HSPAN = 3'd2;
    localparam logic [OP_W-1:0] OP_VSPAN = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // register index, taken from paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
    localparam logic [PIX_W-1:0] WHITE     = 24'hFF_FFFF;

    // 0.30 / 0.59 / 0.11 in 8.8, weights sum to 256
    localparam logic [LUMA_W-1:0] LUMA_KR = 16'd77;
    localparam logic [LUMA_W-1:0] LUMA_KG = 16'd151;
    localparam logic [LUMA_W-1:0] LUMA_KB = 16'd28;

    // size register clamped to 1..max
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > max) begin
            res = DIM_W'(max);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [LUMA_W-1:0] luma(input logic [PIX_W-1:0] p);
        logic [LUMA_W-1:0] r, g, b;
        r = LUMA_W'(p[23:16]);
        g = LUMA_W'(p[15:8]);
        b = LUMA_W'(p[7:0]);
        return LUMA_KR * r + LUMA_KG * g + LUMA_KB * b;
    endfunction

endpackage

FILE: src/rgbfb_item_if.sv
// Input item channel: valid/ready handshake plus the operation payload.
// Depends on rgbfb_pkg for field widths.
interface rgbfb_item_if;
    logic                            valid;
    logic                            ready;
    logic [rgbfb_pkg::OP_W-1:0]      operation;
    logic [rgbfb_pkg::COORD_W-1:0]   x_coord;
    logic [rgbfb_pkg::COORD_W-1:0]   y_coord;
    logic [rgbfb_pkg::COORD_W-1:0]   end_coord;
    logic [rgbfb_pkg::CHAN_W-1:0]    red_in;
    logic [rgbfb_pkg::CHAN_W-1:0]    green_in;
    logic [rgbfb_pkg::CHAN_W-1:0]    blue_in;

    modport source (output valid, operation, x_coord, y_coord, end_coord,
                    red_in, green_in, blue_in, input ready);
    modport sink   (input valid, operation, x_coord, y_coord, end_coord,
                    red_in, green_in, blue_in, output ready);
endinterface

FILE: src/rgbfb_result_if.sv
// Result item channel: valid/ready handshake plus the pixel readback payload.
// Depends on rgbfb_pkg for field widths.
interface rgbfb_result_if;
    logic                            valid;
    logic                            ready;
    logic [rgbfb_pkg::CHAN_W-1:0]    red_out;
    logic [rgbfb_pkg::CHAN_W-1:0]    green_out;
    logic [rgbfb_pkg::CHAN_W-1:0]    blue_out;
    logic [rgbfb_pkg::LUMA_W-1:0]    luminance;
    logic                            out_of_range;

    modport source (output valid, red_out, green_out, blue_out, luminance,
                    out_of_range, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, luminance,
                    out_of_range, output ready);
endinterface

FILE: src/rgb_framebuffer_span_engine_unit.sv
// Framebuffer span engine: 24-bit pixel store with pixel, span and clear ops.
// Items are handled one at a time: a span walks its pixels and a clear writes
// W*H entries; the single memory port sets the pace.
// Reset: sizes go to 256x256 and a clearing pass writes white over all
// STORE_DEPTH entries before the first item is taken.
// Depends on rgbfb_pkg, rgbfb_item_if, rgbfb_result_if.
module rgb_framebuffer_span_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rgbfb_item_if.sink                     i_in,
    rgbfb_result_if.source                 o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgbfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [rgbfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [rgbfb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int unsigned AW = rgbfb_pkg::ADDR_W;

    // one-hot sequencer
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_SPAN   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_RDOUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [rgbfb_pkg::DIM_W-1:0] r_width, r_height;
    logic [rgbfb_pkg::DIM_W-1:0] w_eff_w, w_eff_h;

    // latched item
    logic [rgbfb_pkg::OP_W-1:0]    r_op;
    logic [rgbfb_pkg::COORD_W-1:0] r_x, r_y, r_end;
    logic [rgbfb_pkg::PIX_W-1:0]   r_rgb;

    // walk state for spans and clear
    logic [rgbfb_pkg::COORD_W-1:0] r_cur, n_cur, r_last, n_last;
    logic                          r_vert, n_vert;
    logic [AW-1:0]                 r_addr, n_addr, r_clr_last, n_clr_last;
    logic                          r_oor, n_oor;

    // pixel memory
    logic [rgbfb_pkg::PIX_W-1:0] r_mem [rgbfb_pkg::STORE_DEPTH];
    logic [rgbfb_pkg::PIX_W-1:0] r_rd_data;
    logic                        w_we, w_re;
    logic [AW-1:0]               w_mem_addr;
    logic [rgbfb_pkg::PIX_W-1:0] w_wdata;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic                          w_out_load;
    logic [rgbfb_pkg::PIX_W-1:0]   r_out_pix;
    logic [rgbfb_pkg::LUMA_W-1:0]  r_out_luma;
    logic                          r_out_oor;

    logic                          w_accept;
    logic [rgbfb_pkg::COORD_W-1:0] w_lo, w_hi, w_col;
    logic [17:0]                   w_row_addr;   // y*W + col, at most 255*256+255
    logic [17:0]                   w_area;       // W*H
    logic                          w_pix_in, w_span_in;
    logic                          w_cfg_wr;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbfb_pkg::DIM_RESET;
            r_height <= rgbfb_pkg::DIM_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == rgbfb_pkg::REG_WIDTH) begin
                r_width <= pwdata[rgbfb_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[rgbfb_pkg::DIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rgbfb_pkg::REG_HEIGHT) begin
            prdata = rgbfb_pkg::PDATA_W'(r_height);
        end else begin
            prdata = rgbfb_pkg::PDATA_W'(r_width);
        end
    end

    assign w_eff_w = rgbfb_pkg::eff_dim(r_width, rgbfb_pkg::MAX_WIDTH);
    assign w_eff_h = rgbfb_pkg::eff_dim(r_height, rgbfb_pkg::MAX_HEIGHT);

    // ---------------- item intake ----------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.operation;
            r_x   <= i_in.x_coord;
            r_y   <= i_in.y_coord;
            r_end <= i_in.end_coord;
            r_rgb <= {i_in.red_in, i_in.green_in, i_in.blue_in};
        end
    end

    // ---------------- address math ----------------
    // reversed horizontal span is drawn low to high
    assign w_lo  = (r_x <= r_end) ? r_x : r_end;
    assign w_hi  = (r_x <= r_end) ? r_end : r_x;
    assign w_col = (r_op == rgbfb_pkg::OP_HSPAN) ? w_lo : r_x;

    assign w_row_addr = 18'(r_y) * 18'(w_eff_w) + 18'(w_col);
    assign w_area     = 18'(w_eff_w) * 18'(w_eff_h);

    assign w_pix_in = ({1'b0, r_x} < w_eff_w) && ({1'b0, r_y} < w_eff_h);
    // once a walk leaves the image it stays out, so the wrapped address is never used
    assign w_span_in = r_vert ?
        (({1'b0, r_x} < w_eff_w) && ({1'b0, r_cur} < w_eff_h)) :
        (({1'b0, r_cur} < w_eff_w) && ({1'b0, r_y} < w_eff_h));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_last     = r_last;
        n_vert     = r_vert;
        n_addr     = r_addr;
        n_clr_last = r_clr_last;
        n_oor      = r_oor;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_mem_addr = r_addr;
        w_wdata    = r_rgb;
        w_out_load = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (r_op)
                    rgbfb_pkg::OP_WRITE: begin
                        w_we       = w_pix_in;
                        w_mem_addr = AW'(w_row_addr);
                    end
                    rgbfb_pkg::OP_READ: begin
                        w_re       = w_pix_in;
                        w_mem_addr = AW'(w_row_addr);
                        n_oor      = ~w_pix_in;
                        n_state    = ST_RDOUT;
                    end
                    rgbfb_pkg::OP_HSPAN: begin
                        n_cur   = w_lo;
                        n_last  = w_hi;
                        n_vert  = 1'b0;
                        n_addr  = AW'(w_row_addr);
                        n_state = ST_SPAN;
                    end
                    rgbfb_pkg::OP_VSPAN: begin
                        // start row below end row draws nothing
                        n_cur   = r_y;
                        n_last  = r_end;
                        n_vert  = 1'b1;
                        n_addr  = AW'(w_row_addr);
                        n_state = (r_y > r_end) ? ST_IDLE : ST_SPAN;
                    end
                    rgbfb_pkg::OP_CLEAR: begin
                        n_addr     = '0;
                        n_clr_last = AW'(w_area - 18'd1);
                        n_state    = ST_CLEAR;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SPAN: begin
                w_we       = w_span_in;
                w_mem_addr = r_addr;
                n_addr     = r_addr + (r_vert ? AW'(w_eff_w) : AW'(1));
                n_cur      = r_cur + 1'b1;
                if (r_cur == r_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_mem_addr = r_addr;
                w_wdata    = rgbfb_pkg::WHITE;
                n_addr     = r_addr + AW'(1);
                if (r_addr == r_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDOUT: begin
                // wait for the output register to free up
                if (!r_out_valid || o_res.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_clr_last <= AW'(rgbfb_pkg::STORE_DEPTH - 1);
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_clr_last <= n_clr_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_last <= n_last;
        r_vert <= n_vert;
        r_oor  <= n_oor;
    end

    // ---------------- pixel memory, single port ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_mem_addr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_mem_addr];
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_oor <= r_oor;
            if (r_oor) begin
                r_out_pix  <= '0;
                r_out_luma <= '0;
            end else begin
                r_out_pix  <= r_rd_data;
                r_out_luma <= rgbfb_pkg::luma(r_rd_data);
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.red_out      = r_out_pix[23:16];
    assign o_res.green_out    = r_out_pix[15:8];
    assign o_res.blue_out     = r_out_pix[7:0];
    assign o_res.luminance    = r_out_luma;
    assign o_res.out_of_range = r_out_oor;

endmodule
